/* sv/date_sorted_entry_list_macros.svh */
// Assertion macros used by the checker of the sorted entry list.
`ifndef DATE_SORTED_ENTRY_LIST_MACROS_SVH
`define DATE_SORTED_ENTRY_LIST_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DSEL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dsel check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DSEL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dsel check failed");

`endif

/* sv/dsel_pkg.sv */
`default_nettype none

package dsel_pkg;

  localparam int DSEL_DEPTH     = 16;
  localparam int DSEL_DATE_BITS = 32;
  localparam int DSEL_ID_BITS   = 16;

  localparam int MODE_W  = 2;
  localparam int ID_W    = 16;
  localparam int DATE_W  = 32;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP_NEWEST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP_OLDEST = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LOOKUP     = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  // Per-cell move control, priority in field order.
  typedef struct packed {
    logic load_new;
    logic take_left;
    logic take_right;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/dsel_cell.sv */
`default_nettype none

module dsel_cell import dsel_pkg::*; #(
  parameter int DATE_BITS = DSEL_DATE_BITS,
  parameter int ID_BITS   = DSEL_ID_BITS
) (
  input  wire logic                 clk_i,
  input  wire cell_ctrl_t           ctrl_i,
  input  wire logic [DATE_BITS-1:0] new_key_i,
  input  wire logic [ID_BITS-1:0]   new_id_i,
  input  wire logic [DATE_BITS-1:0] left_key_i,
  input  wire logic [ID_BITS-1:0]   left_id_i,
  input  wire logic [DATE_BITS-1:0] right_key_i,
  input  wire logic [ID_BITS-1:0]   right_id_i,
  output logic      [DATE_BITS-1:0] key_o,
  output logic      [ID_BITS-1:0]   id_o,
  output logic                      ge_o,
  output logic                      match_o
);

  logic [DATE_BITS-1:0] key_q, key_d;
  logic [ID_BITS-1:0]   id_q, id_d;

  always_comb begin
    key_d = key_q;
    id_d  = id_q;
    if (ctrl_i.load_new) begin
      key_d = new_key_i;
      id_d  = new_id_i;
    end else if (ctrl_i.take_left) begin
      key_d = left_key_i;
      id_d  = left_id_i;
    end else if (ctrl_i.take_right) begin
      key_d = right_key_i;
      id_d  = right_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    id_q  <= id_d;
  end

  // New date goes ahead of this entry when it is not older.
  assign ge_o    = (new_key_i >= key_q);
  assign match_o = (new_id_i == id_q);
  assign key_o   = key_q;
  assign id_o    = id_q;

endmodule

`default_nettype wire

/* sv/date_sorted_entry_list.sv */
// A result is registered and presented in the cycle after its item is accepted.
// Throughput: one item per cycle unless the input stalls; every cell compares and shifts in parallel.
// The input stalls only while an unread result is held and the output side stalls.
// Reset clears the entry count and the output valid; cell contents stay undefined
// until written and are never read above the entry count.
`default_nettype none

module date_sorted_entry_list import dsel_pkg::*; #(
  parameter int DEPTH     = DSEL_DEPTH,
  parameter int DATE_BITS = DSEL_DATE_BITS,
  parameter int ID_BITS   = DSEL_ID_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic [ID_W-1:0]   entry_id_i,
  input  wire logic [DATE_W-1:0] date_key_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [STAT_W-1:0] status_o,
  output logic      [ID_W-1:0]   result_id_o,
  output logic      [DATE_W-1:0] result_date_o,
  output logic      [COUNT_W-1:0] entry_count_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic [STAT_W-1:0]  status_q, status_d;
  logic [ID_W-1:0]    rid_q, rid_d;
  logic [DATE_W-1:0]  rdate_q, rdate_d;

  logic [DATE_BITS-1:0] new_key;
  logic [ID_BITS-1:0]   new_id;
  logic [DATE_BITS-1:0] cell_key [DEPTH];
  logic [ID_BITS-1:0]   cell_id  [DEPTH];
  cell_ctrl_t           cell_ctrl [DEPTH];
  logic [DEPTH-1:0]     ge, match, occ, ahead, hit, first_hit, oldest;

  logic accept, full, empty, do_ins, do_pop_new, do_pop_old;
  logic [DATE_BITS-1:0] hit_key, old_key;
  logic [ID_BITS-1:0]   old_id;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;

  assign new_key = DATE_BITS'(date_key_i);
  assign new_id  = ID_BITS'(entry_id_i);

  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign do_ins     = accept && (mode_i == MODE_INSERT) && !full;
  assign do_pop_new = accept && (mode_i == MODE_POP_NEWEST) && !empty;
  assign do_pop_old = accept && (mode_i == MODE_POP_OLDEST) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATE_BITS-1:0] left_key, right_key;
    logic [ID_BITS-1:0]   left_id, right_id;
    logic                 ahead_prev;

    assign occ[i]    = (CNT_W'(i) < count_q);
    assign oldest[i] = (count_q == CNT_W'(i + 1));
    // Descending order makes this flag monotone along the row.
    assign ahead[i]  = ge[i] || !occ[i];

    if (i == 0) begin : g_head
      assign left_key   = new_key;
      assign left_id    = new_id;
      assign ahead_prev = 1'b0;
    end else begin : g_body
      assign left_key   = cell_key[i-1];
      assign left_id    = cell_id[i-1];
      assign ahead_prev = ahead[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_key = cell_key[i];
      assign right_id  = cell_id[i];
    end else begin : g_mid
      assign right_key = cell_key[i+1];
      assign right_id  = cell_id[i+1];
    end

    assign cell_ctrl[i].load_new   = do_ins && ahead[i] && !ahead_prev;
    assign cell_ctrl[i].take_left  = do_ins && ahead_prev;
    assign cell_ctrl[i].take_right = do_pop_new;

    dsel_cell #(
      .DATE_BITS(DATE_BITS),
      .ID_BITS  (ID_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[i]),
      .new_key_i  (new_key),
      .new_id_i   (new_id),
      .left_key_i (left_key),
      .left_id_i  (left_id),
      .right_key_i(right_key),
      .right_id_i (right_id),
      .key_o      (cell_key[i]),
      .id_o       (cell_id[i]),
      .ge_o       (ge[i]),
      .match_o    (match[i])
    );
  end

  // Lowest set bit picks the match nearest the newest end.
  assign hit       = match & occ;
  assign first_hit = hit & (~hit + DEPTH'(1));

  always_comb begin
    hit_key = '0;
    old_key = '0;
    old_id  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_key = hit_key | (first_hit[i] ? cell_key[i] : '0);
      old_key = old_key | (oldest[i] ? cell_key[i] : '0);
      old_id  = old_id  | (oldest[i] ? cell_id[i] : '0);
    end
  end

  always_comb begin
    status_d = ST_OK;
    rid_d    = entry_id_i;
    rdate_d  = '0;
    count_d  = count_q;
    case (mode_i)
      MODE_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      MODE_POP_NEWEST: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          rid_d   = ID_W'(cell_id[0]);
          rdate_d = DATE_W'(cell_key[0]);
          count_d = count_q - CNT_W'(1);
        end
      end
      MODE_POP_OLDEST: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          rid_d   = ID_W'(old_id);
          rdate_d = DATE_W'(old_key);
          count_d = count_q - CNT_W'(1);
        end
      end
      MODE_LOOKUP: begin
        if (|hit) begin
          rdate_d = DATE_W'(hit_key);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (accept) begin
      count_q     <= count_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rid_q    <= rid_d;
      rdate_q  <= rdate_d;
    end
  end

  // Count after the item, held with the result.
  logic [CNT_W-1:0] res_count_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_count_q <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign result_id_o   = rid_q;
  assign result_date_o = rdate_q;
  assign entry_count_o = COUNT_W'(res_count_q);

endmodule

`default_nettype wire

/* sv/dsel_chk.sv */
`default_nettype none
`include "date_sorted_entry_list_macros.svh"

module dsel_chk import dsel_pkg::*; #(
  parameter int DEPTH = DSEL_DEPTH
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic [MODE_W-1:0]  mode_i,
  input wire logic [ID_W-1:0]    entry_id_i,
  input wire logic [DATE_W-1:0]  date_key_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [STAT_W-1:0]  status_o,
  input wire logic [ID_W-1:0]    result_id_o,
  input wire logic [DATE_W-1:0]  result_date_o,
  input wire logic [COUNT_W-1:0] entry_count_o
);

  // Each accepted item shows up as a result in the next cycle.
  `DSEL_ASSERT_NXT(a_item_to_result, in_valid_i && !in_stall_o, out_valid_o)

  // An empty pop reports nothing stored and a zero date.
  `DSEL_ASSERT_IMP(a_empty_result, out_valid_o && (status_o == ST_EMPTY),
    (entry_count_o == '0) && (result_date_o == '0))

  // A rejected insert only happens on a full list.
  `DSEL_ASSERT_IMP(a_full_result, out_valid_o && (status_o == ST_FULL),
    entry_count_o == COUNT_W'(DEPTH))

  `DSEL_ASSERT_IMP(a_count_bound, out_valid_o, entry_count_o <= COUNT_W'(DEPTH))

  `DSEL_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(result_id_o) && $stable(result_date_o))

endmodule

bind date_sorted_entry_list dsel_chk #(.DEPTH(DEPTH)) u_dsel_chk (.*);

`default_nettype wire

/* test/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dsel_pkg::*;

  localparam int LIST_DEPTH = DSEL_DEPTH;
  localparam int RANDOM_PER_PHASE = 350;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ID_W-1:0]    rid;
    logic [DATE_W-1:0]  rdate;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
    logic [DATE_W-1:0] date;
    logic [5:0]        reps;
    logic              typed;
    list_result_t      want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] mode = MODE_INSERT;
  logic [ID_W-1:0]   entry_id = '0;
  logic [DATE_W-1:0] date_key = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0]  status;
  logic [ID_W-1:0]    result_id;
  logic [DATE_W-1:0]  result_date;
  logic [COUNT_W-1:0] entry_count;

  // shadow copy of the list, slot 0 newest
  logic [DATE_W-1:0] date_slot [LIST_DEPTH];
  logic [ID_W-1:0]   id_slot [LIST_DEPTH];
  int                held = 0;

  list_result_t      pending_results [$];
  stim_row_t         directed_rows [$];
  logic [ID_W-1:0]   id_pool [6];
  int                mismatch_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  bit                hold_req = 1'b0;

  date_sorted_entry_list i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .entry_id_i    (entry_id),
    .date_key_i    (date_key),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .result_id_o   (result_id),
    .result_date_o (result_date),
    .entry_count_o (entry_count)
  );

  always #6 clk = ~clk;

  function automatic list_result_t predict_list_result(input logic [MODE_W-1:0] m,
                                                       input logic [ID_W-1:0] id,
                                                       input logic [DATE_W-1:0] d);
    list_result_t r;
    int           pos;
    int           i;
    r.status = ST_OK;
    r.rid    = id;
    r.rdate  = '0;
    case (m)
      MODE_INSERT: begin
        if (held >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // new entry lands ahead of equal dates
          pos = 0;
          while (pos < held && d < date_slot[pos]) pos++;
          for (i = held; i > pos; i--) begin
            date_slot[i] = date_slot[i-1];
            id_slot[i]   = id_slot[i-1];
          end
          date_slot[pos] = d;
          id_slot[pos]   = id;
          held++;
        end
      end
      MODE_POP_NEWEST: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.rid   = id_slot[0];
          r.rdate = date_slot[0];
          for (i = 1; i < held; i++) begin
            date_slot[i-1] = date_slot[i];
            id_slot[i-1]   = id_slot[i];
          end
          held--;
        end
      end
      MODE_POP_OLDEST: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          held--;
          r.rid   = id_slot[held];
          r.rdate = date_slot[held];
        end
      end
      default: begin
        i = 0;
        while (i < held && id_slot[i] != id) i++;
        if (i < held) begin
          r.rdate = date_slot[i];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
    endcase
    r.count = COUNT_W'(held);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got 0x%h, want 0x%h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic void add_row(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                                  input logic [DATE_W-1:0] d, input int reps,
                                  input bit typed, input logic [STAT_W-1:0] st,
                                  input logic [ID_W-1:0] rid, input logic [DATE_W-1:0] rdate,
                                  input int count);
    stim_row_t row;
    row.mode         = m;
    row.id           = id;
    row.date         = d;
    row.reps         = 6'(reps);
    row.typed        = typed;
    row.want.status  = st;
    row.want.rid     = rid;
    row.want.rdate   = rdate;
    row.want.count   = COUNT_W'(count);
    directed_rows.push_back(row);
  endfunction

  // Starts and ends at a falling edge; the prediction is taken when the item is accepted.
  task automatic drive_item(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                            input logic [DATE_W-1:0] d, input bit typed,
                            input list_result_t want);
    list_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    entry_id <= id;
    date_key <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_list_result(m, id, d);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic drive_random_item(input int insert_pct);
    logic [MODE_W-1:0] m;
    logic [ID_W-1:0]   id;
    logic [DATE_W-1:0] d;
    if ($urandom_range(99) < insert_pct) begin
      m = MODE_INSERT;
    end else begin
      case ($urandom_range(2))
        0:       m = MODE_POP_NEWEST;
        1:       m = MODE_POP_OLDEST;
        default: m = MODE_LOOKUP;
      endcase
    end
    // a small id pool makes lookups hit and duplicates appear
    if ($urandom_range(99) < 70) id = id_pool[$urandom_range(5)];
    else id = ID_W'($urandom);
    case ($urandom_range(9))
      0:       d = '0;
      1:       d = '1;
      2, 3:    d = DATE_W'($urandom_range(3));
      default: d = DATE_W'($urandom);
    endcase
    drive_item(m, id, d, 1'b0, '0);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin : stall_driver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 60;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item pending", 32'(status), 32'(0));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", 32'(status), 32'(want.status));
        if (result_id !== want.rid) report_mismatch("result_id", 32'(result_id), 32'(want.rid));
        if (result_date !== want.rdate) report_mismatch("result_date", result_date, want.rdate);
        if (entry_count !== want.count) begin
          report_mismatch("entry_count", 32'(entry_count), 32'(want.count));
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int        k;
    int        phase;
    int        n;
    int        send_pct [4];
    int        recv_pct [4];
    send_pct = '{0, 62, 0, 30};
    recv_pct = '{0, 0, 62, 30};

    add_row(MODE_POP_NEWEST, 16'h0000, 32'h0000_0000, 1, 1, ST_EMPTY, 16'h0000, '0, 0);
    add_row(MODE_POP_OLDEST, 16'hFFFF, 32'hFFFF_FFFF, 1, 1, ST_EMPTY, 16'hFFFF, '0, 0);
    add_row(MODE_LOOKUP, 16'h5A5A, 32'h0000_0000, 1, 1, ST_NOT_FOUND, 16'h5A5A, '0, 0);
    add_row(MODE_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1, 1, ST_OK, 16'hFFFF, '0, 1);
    add_row(MODE_INSERT, 16'h0000, 32'h0000_0000, 1, 1, ST_OK, 16'h0000, '0, 2);
    // equal date: goes ahead of the stored one
    add_row(MODE_INSERT, 16'h1234, 32'hFFFF_FFFF, 1, 0, ST_OK, '0, '0, 0);
    add_row(MODE_LOOKUP, 16'hFFFF, 32'h0000_0000, 1, 1, ST_OK, 16'hFFFF, 32'hFFFF_FFFF, 3);
    add_row(MODE_POP_NEWEST, 16'h0000, 32'h0000_0000, 1, 0, ST_OK, '0, '0, 0);
    add_row(MODE_POP_OLDEST, 16'h7777, 32'h0000_0000, 1, 1, ST_OK, 16'h0000, '0, 1);
    add_row(MODE_LOOKUP, 16'h0000, 32'h0000_0000, 1, 1, ST_NOT_FOUND, 16'h0000, '0, 1);
    add_row(MODE_INSERT, 16'h0100, 32'h8000_0000, 15, 0, ST_OK, '0, '0, 0);
    add_row(MODE_INSERT, 16'hABCD, 32'h1234_5678, 1, 1, ST_FULL, 16'hABCD, '0, LIST_DEPTH);
    add_row(MODE_LOOKUP, 16'h0107, 32'h0000_0000, 1, 0, ST_OK, '0, '0, 0);
    add_row(MODE_POP_OLDEST, 16'h0000, 32'h0000_0000, 16, 0, ST_OK, '0, '0, 0);
    add_row(MODE_POP_NEWEST, 16'h0000, 32'h0000_0000, 1, 1, ST_EMPTY, 16'h0000, '0, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (k = 0; k < row.reps; k++) begin
        drive_item(row.mode, row.id + ID_W'(k), row.date, row.typed, row.want);
      end
    end
    wait_for_results();

    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      foreach (id_pool[p]) id_pool[p] = ID_W'($urandom);
      // long output hold while items keep coming, so the input backs up
      if (phase == 0) hold_req = 1'b1;
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        // alternate fill-heavy and drain-heavy stretches
        drive_random_item(((n / 40) % 2 == 0) ? 70 : 25);
      end
      if (phase == 3) recv_stall_pct = 0;
      wait_for_results();
    end

    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
